// ===== hdl/aogc_pkg.sv =====
// ----------------------------------------------------------------------------
// aogc_pkg
// Types and constants for the converter offset and gain calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package aogc_pkg;

    localparam int SAMPLE_W       = 24;
    localparam int DIFF_W         = 25;
    localparam int SUM_W          = 32;
    localparam int COUNT_W        = 8;
    localparam int GAIN_W         = 24;
    localparam int GAIN_REGS      = 4;
    localparam int GAIN_IDX_W     = 2;
    localparam int GAIN_FRAC_BITS = 22;
    localparam int CHAN_W         = 2;
    localparam int PROD_W         = SAMPLE_W + GAIN_W;

    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 24'h400000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // divider: one quotient bit per cycle over the whole sum
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic OP_CAL  = 1'b0;
    localparam logic OP_CONV = 1'b1;

    // one memory word per channel
    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [COUNT_W-1:0]  count;
        logic [SAMPLE_W-1:0] offset;
    } aogc_entry_t;

endpackage

`default_nettype wire

// ===== hdl/adc_offset_gain_calibrator.sv =====
// ----------------------------------------------------------------------------
// adc_offset_gain_calibrator
// Per-channel offset averaging and Q2.22 gain correction of converter codes.
// ----------------------------------------------------------------------------
//
//  Port group  Dir  Handshake          Contents
//  ----------  ---  -----------------  ------------------------------------
//  in          in   in_valid/in_ready  operation, channel, sample_code
//  out         out  out_valid/out_ready offset_removed, corrected_code,
//                                       offset_average
//  cfg         in   cfg_we             cfg_index, cfg_data (gain registers)
//
//  Calibration request: memory read, bit-serial divider (32 steps),
//  write-back, then output.
//  A calibration request on a saturated channel skips the divider and write-back.
//  Conversion request: memory read, multiply, scale, output.
//  One request in flight; the next is accepted once the result is in the
//  output register, even if it has not yet been taken.
//  Reset clears per-channel state through entry valid bits; gains go to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_offset_gain_calibrator #(
    parameter int CHANNELS = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                operation,
    input  wire logic [aogc_pkg::CHAN_W-1:0]         channel,
    input  wire logic signed [aogc_pkg::SAMPLE_W-1:0] sample_code,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [aogc_pkg::DIFF_W-1:0]       offset_removed,
    output logic [aogc_pkg::SAMPLE_W-1:0]            corrected_code,
    output logic signed [aogc_pkg::SAMPLE_W-1:0]     offset_average,

    input  wire logic                                cfg_we,
    input  wire logic [aogc_pkg::GAIN_IDX_W-1:0]     cfg_index,
    input  wire logic [aogc_pkg::GAIN_W-1:0]         cfg_data
);
    import aogc_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]                state_reg;
    logic [2:0]                state_next;

    logic [GAIN_W-1:0]         gain_reg [GAIN_REGS];

    // per-channel state memory
    aogc_entry_t               mem [CHANNELS];
    logic [CHANNELS-1:0]       ent_vld_reg;
    aogc_entry_t               rd_data_reg;
    logic                      rd_vld_reg;
    logic                      mem_we;
    aogc_entry_t               wr_data;

    // latched request
    logic                      op_reg;
    logic [CHAN_W-1:0]         ch_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic                      ch_ok_reg;
    logic [SAMPLE_W-1:0]       sample_reg;
    logic                      ch_ok;
    logic [ADDR_W-1:0]         in_addr;

    // calibration datapath
    aogc_entry_t               ent;
    logic [SUM_W-1:0]          sum_new;
    logic [COUNT_W-1:0]        cnt_new;
    logic [SUM_W-1:0]          sum_reg;
    logic [COUNT_W-1:0]        cnt_reg;
    logic                      sum_neg_reg;
    logic [SUM_W-1:0]          quo_reg;
    logic [COUNT_W-1:0]        rem_reg;
    logic [COUNT_W:0]          rem_sh;
    logic                      rem_ge;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic [SAMPLE_W-1:0]       ofs_new;

    // conversion datapath
    logic [DIFF_W-1:0]         diff;
    logic [DIFF_W-1:0]         diff_reg;
    logic [SAMPLE_W-1:0]       mag_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [SAMPLE_W-1:0]       q_lo;

    // staged result
    logic [DIFF_W-1:0]         res_rem_reg;
    logic [SAMPLE_W-1:0]       res_cor_reg;
    logic [SAMPLE_W-1:0]       res_ofs_reg;

    logic                      out_valid_reg;
    logic [DIFF_W-1:0]         out_rem_reg;
    logic [SAMPLE_W-1:0]       out_cor_reg;
    logic [SAMPLE_W-1:0]       out_ofs_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign ch_ok    = (int'(channel) < CHANNELS);
    assign in_addr  = ADDR_W'(channel);

    assign ent     = rd_vld_reg ? rd_data_reg : '0;
    assign sum_new = ent.sum + {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign cnt_new = ent.count + COUNT_W'(1);
    assign diff    = {sample_reg[SAMPLE_W-1], sample_reg}
                   - {ent.offset[SAMPLE_W-1], ent.offset};

    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, cnt_reg});

    assign ofs_new = sum_neg_reg ? (SAMPLE_W'(0) - quo_reg[SAMPLE_W-1:0])
                                 : quo_reg[SAMPLE_W-1:0];
    assign q_lo    = prod_reg[GAIN_FRAC_BITS +: SAMPLE_W];

    assign mem_we       = (state_reg == ST_WB);
    assign wr_data.sum    = sum_reg;
    assign wr_data.count  = cnt_reg;
    assign wr_data.offset = ofs_new;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (!ch_ok_reg)
                    state_next = ST_OUT;
                else if (op_reg == OP_CONV)
                    state_next = ST_MUL;
                else if (ent.count == COUNT_MAX)
                    state_next = ST_OUT;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                    state_next = ST_WB;
            end
            ST_WB:    state_next = ST_OUT;
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ent_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < GAIN_REGS; i++)
                gain_reg[i] <= GAIN_ONE;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
                ent_vld_reg[addr_reg] <= 1'b1;
            if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
                gain_reg[cfg_index] <= cfg_data;
        end
    end

    // state memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && ch_ok)
        begin
            rd_data_reg <= mem[in_addr];
            rd_vld_reg  <= ent_vld_reg[in_addr];
        end
        if (mem_we)
            mem[addr_reg] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_reg     <= operation;
                    ch_reg     <= channel;
                    addr_reg   <= in_addr;
                    ch_ok_reg  <= ch_ok;
                    sample_reg <= sample_code;
                end
            end
            ST_READ:
            begin
                sum_reg     <= sum_new;
                cnt_reg     <= cnt_new;
                sum_neg_reg <= sum_new[SUM_W-1];
                quo_reg     <= sum_new[SUM_W-1] ? (SUM_W'(0) - sum_new) : sum_new;
                rem_reg     <= '0;
                div_cnt_reg <= '0;
                diff_reg    <= diff;
                mag_reg     <= diff[DIFF_W-1] ? SAMPLE_W'(DIFF_W'(0) - diff)
                                              : diff[SAMPLE_W-1:0];
                res_rem_reg <= '0;
                res_cor_reg <= '0;
                res_ofs_reg <= ch_ok_reg ? ent.offset : '0;
            end
            ST_DIV:
            begin
                rem_reg     <= rem_ge ? COUNT_W'(rem_sh - {1'b0, cnt_reg})
                                      : rem_sh[COUNT_W-1:0];
                quo_reg     <= {quo_reg[SUM_W-2:0], rem_ge};
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_WB:
            begin
                res_ofs_reg <= ofs_new;
            end
            ST_MUL:
            begin
                prod_reg <= PROD_W'(mag_reg) * PROD_W'(gain_reg[ch_reg]);
            end
            ST_SCALE:
            begin
                res_rem_reg <= diff_reg;
                res_cor_reg <= diff_reg[DIFF_W-1] ? (SAMPLE_W'(0) - q_lo) : q_lo;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_rem_reg <= res_rem_reg;
                    out_cor_reg <= res_cor_reg;
                    out_ofs_reg <= res_ofs_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign offset_removed = out_rem_reg;
    assign corrected_code = out_cor_reg;
    assign offset_average = out_ofs_reg;

    // divisor is a count of at least one sample
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg != '0)
        else $error("divider running with zero count");

    // restoring divider keeps remainder below divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < cnt_reg)
        else $error("divider remainder out of range");

    // only calibration on a real channel writes the state memory
    a_wb_cal: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (op_reg == OP_CAL && ch_ok_reg))
        else $error("state write from conversion or bad channel");

    // accepted request always goes to the memory read cycle
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == ST_READ)
        else $error("accepted request skipped memory read");

    // result register only loads when free or being drained
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && state_reg == ST_OUT) |=> state_reg == ST_OUT)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
